// ===== rtl/pcfs_pkg.sv =====
package pcfs_pkg;

   localparam int DEF_MAX_ROWS  = 1024;
   localparam int DEF_MAX_EDGES = 8192;
   localparam int DEF_FRAC_BITS = 16;

   localparam int OP_W      = 2;
   localparam int MEAS_W    = 16;
   localparam int COL_W     = 10;
   localparam int ROW_W     = 10;
   localparam int MARK_W    = 2;
   localparam int ROUNDS_W  = 11;
   localparam int LIMIT_W   = 9;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD = 2'd0,
      OP_EDGE = 2'd1,
      OP_RUN  = 2'd2,
      OP_READ = 2'd3
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PMIS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ISO   = 2'd2;

   localparam logic [MARK_W-1:0] MARK_NONE   = 2'b00;
   localparam logic [MARK_W-1:0] MARK_COARSE = 2'b01;
   localparam logic [MARK_W-1:0] MARK_FINE   = 2'b11;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_READ  = 9'b000000010,
      ST_ROW   = 9'b000000100,
      ST_ROWD  = 9'b000001000,
      ST_EDGE  = 9'b000010000,
      ST_EDGED = 9'b000100000,
      ST_NBRD  = 9'b001000000,
      ST_ROUND = 9'b010000000,
      ST_FIN   = 9'b100000000
   } state_type;

   typedef enum logic [5:0] {
      PH_DEG   = 6'b000001,
      PH_SEL   = 6'b000010,
      PH_MARK  = 6'b000100,
      PH_FORCE = 6'b001000,
      PH_COUNT = 6'b010000,
      PH_FINAL = 6'b100000
   } phase_type;

endpackage

// ===== rtl/pcfs_ram.sv =====
module pcfs_ram
   import pcfs_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_ROWS,
   parameter int WIDTH = MARK_W
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/pmis_coarse_fine_splitter.sv =====
// A load or neighbour transfer answers in the cycle after it is taken, a read
// after ST_READ. A run walks the stored graph with one memory access per cycle:
// each row passes ST_ROW and ST_ROWD, each edge ST_EDGE, ST_EDGED and, for a
// valid select column, ST_NBRD. Degree and final passes run once; select, mark,
// force (and count when unlimited) repeat per Luby round. One item at a time.
// Reset (synchronous, active high) clears control state only, limit to all 1s.
module pmis_coarse_fine_splitter
   import pcfs_pkg::*;
#(
   parameter int MAX_ROWS              = DEF_MAX_ROWS,
   parameter int MAX_EDGES             = DEF_MAX_EDGES,
   parameter int MEASURE_FRACTION_BITS = DEF_FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OP_W-1:0]            req_op,
   input  logic [MEAS_W-1:0]          req_measure,
   input  logic [COL_W-1:0]           req_neighbour,
   input  logic [ROW_W-1:0]           req_row,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [MARK_W-1:0]   rsp_marker,
   output logic [ROUNDS_W-1:0]        rsp_rounds_used,
   output logic                       rsp_error,
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [LIMIT_W-1:0]         csr_wdata
);

   localparam int FB   = MEASURE_FRACTION_BITS;
   localparam int AW   = $clog2(MAX_ROWS);
   localparam int RC_W = $clog2(MAX_ROWS + 1);
   localparam int EAW  = $clog2(MAX_EDGES);
   localparam int EC_W = $clog2(MAX_EDGES + 1);
   localparam int KW   = EC_W + FB;
   localparam int CW   = (RC_W > COL_W) ? RC_W : COL_W;

   // control
   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [RC_W-1:0]      row_count_ff, row_count_in;
   logic [EC_W-1:0]      edge_count_ff, edge_count_in;
   logic [ROUNDS_W-1:0]  round_count_ff, round_count_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic                 pmis_ff, pmis_in;
   logic                 iso_ff, iso_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RC_W-1:0]      undecided_ff, undecided_in;
   logic                 picked_ff, picked_in;
   logic                 ok_ff, ok_in;
   // datapath
   logic [RC_W-1:0]      i_ff, i_in;
   logic [EC_W-1:0]      e_ff, e_in;
   logic [EC_W-1:0]      e_end_ff, e_end_in;
   logic [EC_W-1:0]      prev_end_ff, prev_end_in;
   logic [EC_W-1:0]      deg_ff, deg_in;
   logic [KW-1:0]        cur_key_ff, cur_key_in;
   logic [MARK_W-1:0]    rsp_marker_ff, rsp_marker_in;
   logic                 rsp_error_ff, rsp_error_in;

   // memory ports
   logic                 key_we, mark_we, end_we, edge_we, sel_we;
   logic [AW-1:0]        key_waddr, mark_waddr, end_waddr, sel_waddr, nbr_raddr;
   logic [EAW-1:0]       edge_waddr;
   logic [KW-1:0]        key_wdata, key_rd;
   logic [MARK_W-1:0]    mark_wdata, mark_rd;
   logic [EC_W-1:0]      end_wdata, end_rd;
   logic [COL_W-1:0]     edge_rd;
   logic                 sel_wdata, sel_rd;

   logic                 req_xfer;
   logic                 unlimited;
   logic                 col_ok;
   logic                 beats;
   logic                 row_zero;
   logic [RC_W-1:0]      rc_eff;
   logic [EC_W-1:0]      ec_eff;
   logic [FB-1:0]        meas_frac;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_xfer  = req_valid && req_ready;
   assign unlimited = limit_ff[LIMIT_W-1] || (limit_ff == '0);
   // a column counts only when it names another loaded row
   assign col_ok    = (CW'(edge_rd) < CW'(row_count_ff)) && (CW'(edge_rd) != CW'(i_ff));
   // in PMIS mode the comparison is turned round
   assign beats     = pmis_ff ? (cur_key_ff <= key_rd) : (cur_key_ff >= key_rd);
   assign row_zero  = (req_row == '0);
   assign rc_eff    = row_zero ? '0 : row_count_ff;
   assign ec_eff    = row_zero ? '0 : edge_count_ff;
   assign meas_frac = FB'(req_measure);

   assign nbr_raddr = (state_ff == ST_IDLE)  ? AW'(req_row) :
                      (state_ff == ST_EDGED) ? AW'(edge_rd) : AW'(i_ff);

   pcfs_ram #(.DEPTH(MAX_ROWS), .WIDTH(KW)) u_key (
      .clock, .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
      .raddr(nbr_raddr), .rdata(key_rd));

   pcfs_ram #(.DEPTH(MAX_ROWS), .WIDTH(MARK_W)) u_mark (
      .clock, .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
      .raddr(nbr_raddr), .rdata(mark_rd));

   pcfs_ram #(.DEPTH(MAX_ROWS), .WIDTH(EC_W)) u_end (
      .clock, .we(end_we), .waddr(end_waddr), .wdata(end_wdata),
      .raddr(AW'(i_ff)), .rdata(end_rd));

   pcfs_ram #(.DEPTH(MAX_EDGES), .WIDTH(COL_W)) u_edge (
      .clock, .we(edge_we), .waddr(edge_waddr), .wdata(req_neighbour),
      .raddr(e_ff[EAW-1:0]), .rdata(edge_rd));

   pcfs_ram #(.DEPTH(MAX_ROWS), .WIDTH(1)) u_sel (
      .clock, .we(sel_we), .waddr(sel_waddr), .wdata(sel_wdata),
      .raddr(AW'(i_ff)), .rdata(sel_rd));

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      row_count_in   = row_count_ff;
      edge_count_in  = edge_count_ff;
      round_count_in = round_count_ff;
      limit_in       = limit_ff;
      pmis_in        = pmis_ff;
      iso_in         = iso_ff;
      undecided_in   = undecided_ff;
      picked_in      = picked_ff;
      ok_in          = ok_ff;
      i_in           = i_ff;
      e_in           = e_ff;
      e_end_in       = e_end_ff;
      prev_end_in    = prev_end_ff;
      deg_in         = deg_ff;
      cur_key_in     = cur_key_ff;
      rsp_marker_in  = rsp_marker_ff;
      rsp_error_in   = rsp_error_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      key_we     = 1'b0;
      key_waddr  = AW'(i_ff);
      key_wdata  = {deg_ff, cur_key_ff[FB-1:0]};
      mark_we    = 1'b0;
      mark_waddr = AW'(i_ff);
      mark_wdata = MARK_NONE;
      end_we     = 1'b0;
      end_waddr  = AW'(req_row);
      end_wdata  = ec_eff;
      edge_we    = 1'b0;
      edge_waddr = edge_count_ff[EAW-1:0];
      sel_we     = 1'b0;
      sel_waddr  = AW'(i_ff);
      sel_wdata  = ok_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_LIMIT: limit_in = csr_wdata;
            CSR_PMIS:  pmis_in  = csr_wdata[0];
            CSR_ISO:   iso_in   = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               rsp_marker_in = MARK_NONE;
               rsp_error_in  = 1'b0;
               case (op_type'(req_op))
                  OP_LOAD: begin
                     rsp_valid_in = 1'b1;
                     row_count_in = rc_eff;
                     edge_count_in = ec_eff;
                     if (RC_W'(req_row) == rc_eff && CW'(req_row) == CW'(rc_eff)
                         && rc_eff < RC_W'(MAX_ROWS)) begin
                        key_we       = 1'b1;
                        key_waddr    = AW'(req_row);
                        key_wdata    = KW'(meas_frac);
                        mark_we      = 1'b1;
                        mark_waddr   = AW'(req_row);
                        mark_wdata   = MARK_NONE;
                        end_we       = 1'b1;
                        row_count_in = rc_eff + 1'b1;
                     end else begin
                        rsp_error_in = 1'b1;
                     end
                  end
                  OP_EDGE: begin
                     rsp_valid_in = 1'b1;
                     if (row_count_ff == '0 || edge_count_ff >= EC_W'(MAX_EDGES)) begin
                        rsp_error_in = 1'b1;
                     end else begin
                        edge_we       = 1'b1;
                        edge_count_in = edge_count_ff + 1'b1;
                        end_we        = 1'b1;
                        end_waddr     = AW'(row_count_ff - 1'b1);
                        end_wdata     = edge_count_ff + 1'b1;
                     end
                  end
                  OP_RUN: begin
                     round_count_in = '0;
                     phase_in       = PH_DEG;
                     i_in           = '0;
                     prev_end_in    = '0;
                     undecided_in   = '0;
                     state_in       = ST_ROW;
                  end
                  OP_READ: begin
                     if (CW'(req_row) < CW'(row_count_ff)) begin
                        state_in = ST_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_error_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_READ: begin
            rsp_marker_in = mark_rd;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end

         ST_ROW: begin
            if (i_ff == row_count_ff) begin
               // end of a pass over all rows
               i_in        = '0;
               prev_end_in = '0;
               case (phase_ff)
                  PH_DEG:  state_in = ST_ROUND;
                  PH_SEL:  phase_in = PH_MARK;
                  PH_MARK: phase_in = PH_FORCE;
                  PH_FORCE: begin
                     round_count_in = round_count_ff + 1'b1;
                     if (unlimited) begin
                        phase_in     = PH_COUNT;
                        undecided_in = '0;
                     end else begin
                        state_in = ST_ROUND;
                     end
                  end
                  PH_COUNT: begin
                     if (!picked_ff) begin
                        phase_in = PH_FINAL;
                     end else begin
                        state_in = ST_ROUND;
                     end
                  end
                  PH_FINAL: state_in = ST_FIN;
                  default:  state_in = ST_FIN;
               endcase
            end else begin
               state_in = ST_ROWD;
            end
         end

         ST_ROWD: begin
            e_end_in   = end_rd;
            e_in       = prev_end_ff;
            cur_key_in = key_rd;
            deg_in     = '0;
            // default: advance to the next row
            i_in        = i_ff + 1'b1;
            prev_end_in = end_rd;
            state_in    = ST_ROW;
            case (phase_ff)
               PH_DEG: begin
                  i_in        = i_ff;
                  prev_end_in = prev_end_ff;
                  state_in    = ST_EDGE;
               end
               PH_SEL: begin
                  ok_in = (mark_rd == MARK_NONE);
                  if (mark_rd == MARK_NONE) begin
                     i_in        = i_ff;
                     prev_end_in = prev_end_ff;
                     state_in    = ST_EDGE;
                  end else begin
                     sel_we    = 1'b1;
                     sel_wdata = 1'b0;
                  end
               end
               PH_MARK: begin
                  if (sel_rd) begin
                     mark_we    = 1'b1;
                     mark_wdata = MARK_FINE;
                  end
               end
               PH_FORCE: begin
                  if (sel_rd) begin
                     i_in        = i_ff;
                     prev_end_in = prev_end_ff;
                     state_in    = ST_EDGE;
                  end
               end
               PH_COUNT: begin
                  if (mark_rd == MARK_NONE) begin
                     undecided_in = undecided_ff + 1'b1;
                  end
               end
               PH_FINAL: begin
                  mark_we    = 1'b1;
                  mark_wdata = ((mark_rd == MARK_FINE) != pmis_ff) ? MARK_FINE : MARK_COARSE;
               end
               default: ;
            endcase
         end

         ST_EDGE: begin
            if (e_ff == e_end_ff || (phase_ff == PH_SEL && !ok_ff)) begin
               // row finished
               i_in        = i_ff + 1'b1;
               prev_end_in = e_end_ff;
               state_in    = ST_ROW;
               case (phase_ff)
                  PH_DEG: begin
                     key_we  = 1'b1;
                     mark_we = 1'b1;
                     if (deg_ff == '0) begin
                        mark_wdata = (iso_ff ? !pmis_ff : pmis_ff) ? MARK_COARSE : MARK_FINE;
                     end else begin
                        mark_wdata   = MARK_NONE;
                        undecided_in = undecided_ff + 1'b1;
                     end
                  end
                  PH_SEL: begin
                     sel_we = 1'b1;
                     if (ok_ff) begin
                        picked_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end else begin
               state_in = ST_EDGED;
            end
         end

         ST_EDGED: begin
            e_in     = e_ff + 1'b1;
            state_in = ST_EDGE;
            if (col_ok) begin
               case (phase_ff)
                  PH_DEG: deg_in = deg_ff + 1'b1;
                  PH_SEL: state_in = ST_NBRD;
                  PH_FORCE: begin
                     mark_we    = 1'b1;
                     mark_waddr = AW'(edge_rd);
                     mark_wdata = MARK_COARSE;
                  end
                  default: ;
               endcase
            end
         end

         ST_NBRD: begin
            // drop the row when an undecided neighbour does not lose to it
            if (mark_rd == MARK_NONE && beats) begin
               ok_in = 1'b0;
            end
            state_in = ST_EDGE;
         end

         ST_ROUND: begin
            i_in        = '0;
            prev_end_in = '0;
            state_in    = ST_ROW;
            if (unlimited ? (undecided_ff == '0)
                          : (round_count_ff >= ROUNDS_W'(limit_ff[LIMIT_W-2:0]))) begin
               phase_in = PH_FINAL;
            end else begin
               phase_in  = PH_SEL;
               picked_in = 1'b0;
            end
         end

         ST_FIN: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= PH_DEG;
         row_count_ff   <= '0;
         edge_count_ff  <= '0;
         round_count_ff <= '0;
         limit_ff       <= '1;
         pmis_ff        <= 1'b0;
         iso_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         undecided_ff   <= '0;
         picked_ff      <= 1'b0;
         ok_ff          <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         row_count_ff   <= row_count_in;
         edge_count_ff  <= edge_count_in;
         round_count_ff <= round_count_in;
         limit_ff       <= limit_in;
         pmis_ff        <= pmis_in;
         iso_ff         <= iso_in;
         rsp_valid_ff   <= rsp_valid_in;
         undecided_ff   <= undecided_in;
         picked_ff      <= picked_in;
         ok_ff          <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      e_ff          <= e_in;
      e_end_ff      <= e_end_in;
      prev_end_ff   <= prev_end_in;
      deg_ff        <= deg_in;
      cur_key_ff    <= cur_key_in;
      rsp_marker_ff <= rsp_marker_in;
      rsp_error_ff  <= rsp_error_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_marker      = rsp_marker_ff;
   assign rsp_rounds_used = round_count_ff;
   assign rsp_error       = rsp_error_ff;

endmodule

// ===== rtl/pcfs_checker.sv =====
module pcfs_checker
   import pcfs_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [MARK_W-1:0] rsp_marker,
   input logic                     rsp_error
);

   // a waiting result holds until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_err_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_marker == MARK_NONE)
      else $error("refused request carries a marker");

   a_marker_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_marker != 2'b10)
      else $error("illegal marker code");

   a_one_at_once: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_ready)
      else $error("request taken while a result is stuck");

endmodule

bind pmis_coarse_fine_splitter pcfs_checker u_pcfs_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_marker(rsp_marker),
   .rsp_error(rsp_error));
